@@ rtl/mpfe_pkg.sv @@
// Shared constants, codes and transaction types of the page framebuffer engine.
`timescale 1ns / 1ps

package mpfe_pkg;

    localparam int PANEL_WIDTH  = 128;
    localparam int PAGE_COUNT   = 8;
    localparam int PANEL_HEIGHT = PAGE_COUNT * 8;
    localparam int STORE_DEPTH  = PAGE_COUNT * PANEL_WIDTH;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int COL_W        = $clog2(PANEL_WIDTH);
    localparam int PAGE_W       = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

    localparam logic [2:0] OP_CLEAR_ALL   = 3'd0;
    localparam logic [2:0] OP_INVERT_ALL  = 3'd1;
    localparam logic [2:0] OP_SET_PIXEL   = 3'd2;
    localparam logic [2:0] OP_CLEAR_RECT  = 3'd3;
    localparam logic [2:0] OP_INVERT_RECT = 3'd4;
    localparam logic [2:0] OP_BLIT_BYTE   = 3'd5;
    localparam logic [2:0] OP_READ        = 3'd6;

    // What the write stage does with one store byte.
    typedef enum logic [1:0] {
        KIND_ANDN = 2'd0,
        KIND_XOR  = 2'd1,
        KIND_OR   = 2'd2,
        KIND_READ = 2'd3
    } mpfe_kind_t;

    typedef struct packed {
        logic [2:0] op;
        logic [6:0] x;
        logic [5:0] y;
        logic [7:0] width;
        logic [6:0] height;
        logic [6:0] src_col;
        logic [2:0] src_row;
        logic [7:0] src_byte;
    } mpfe_cmd_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       applied;
    } mpfe_res_t;

endpackage

@@ rtl/mono_page_framebuffer_engine_core.sv @@
// One-bit-per-pixel page framebuffer with a byte-walking read-modify-write sequencer.
`timescale 1ns / 1ps

// The block takes one command transaction on cmd (cmd_valid / cmd_ready) and
// returns exactly one result transaction on res (res_valid / res_ready).
// A command is decoded and clipped in the cycle it is accepted. The sequencer
// then walks every store byte the command touches, one byte per cycle, through
// a single-port-read, single-port-write memory: the read is issued in one
// cycle and the modified byte is written back in the next, overlapped with the
// next read. Set pixel and read touch one byte, a blit one or two, a rectangle
// columns times pages, and clear all and invert all every byte of the store.
// A command that is clipped away or uses an unused code still returns its
// result, without walking the store.
// cmd_ready is high only while the sequencer is idle; a new command may be
// accepted while the previous result still waits in the output register.
// When the receiver stalls, a finished result waits until the output register
// is free, and the block holds cmd_ready low meanwhile.
// After reset the sequencer clears the whole store, one byte per cycle, with
// cmd_ready low; no result is produced.
module mono_page_framebuffer_engine_core
    import mpfe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  mpfe_cmd_t cmd,
    output logic      res_valid,
    input  logic      res_ready,
    output mpfe_res_t res
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_WALK   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic              report_reg, report_next;
    logic [PAGE_W-1:0] page_reg, page_next;
    logic [PAGE_W-1:0] page_start_reg, page_start_next;
    logic [PAGE_W-1:0] page_end_reg, page_end_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [COL_W-1:0]  col_start_reg, col_start_next;
    logic [COL_W-1:0]  col_end_reg, col_end_next;
    logic [ADDR_W-1:0] row_base_reg, row_base_next;
    logic [2:0]        y_lo_reg, y_lo_next;
    logic [2:0]        y_hi_reg, y_hi_next;
    mpfe_kind_t        kind_reg, kind_next;
    logic              blit_reg, blit_next;
    logic [7:0]        blit_lo_reg, blit_lo_next;
    logic [7:0]        blit_hi_reg, blit_hi_next;
    logic              res_applied_reg, res_applied_next;
    logic [7:0]        res_data_reg, res_data_next;
    logic              p1_valid_reg, p1_valid_next;
    logic [ADDR_W-1:0] p1_addr_reg, p1_addr_next;
    logic [7:0]        p1_mask_reg, p1_mask_next;
    mpfe_kind_t        p1_kind_reg, p1_kind_next;
    logic              res_valid_reg, res_valid_next;
    mpfe_res_t         res_reg, res_next;

    logic [7:0]        mem [STORE_DEPTH];
    logic [7:0]        mem_rdata_reg;
    logic              mem_we;
    logic [7:0]        mem_wdata;

    // Command decode and clipping.
    logic [8:0]        x_w, y_w, x_end, y_end, x_end_c, y_end_c, x_last, y_last;
    logic [8:0]        y_page, y_last_page;
    logic              x_on, y_on, rect_ok;
    logic [8:0]        b_col, b_page, b_page_inc;
    logic              b_ok, b_two;
    logic [15:0]       b_shifted;

    logic              setup_walk;
    logic              setup_applied;
    logic [PAGE_W-1:0] setup_page_start, setup_page_end;
    logic [COL_W-1:0]  setup_col_start, setup_col_end;
    logic [2:0]        setup_y_lo, setup_y_hi;
    mpfe_kind_t        setup_kind;
    logic              setup_blit;

    // Walk address and per-byte mask.
    logic [ADDR_W-1:0] walk_addr;
    logic [2:0]        mask_lo, mask_hi;
    logic [7:0]        range_mask, walk_mask;

    assign x_w     = {2'b00, cmd.x};
    assign y_w     = {3'b000, cmd.y};
    assign x_on    = x_w < 9'(PANEL_WIDTH);
    assign y_on    = y_w < 9'(PANEL_HEIGHT);
    assign x_end   = x_w + {1'b0, cmd.width};
    assign y_end   = y_w + {2'b00, cmd.height};
    assign x_end_c = (x_end > 9'(PANEL_WIDTH)) ? 9'(PANEL_WIDTH) : x_end;
    assign y_end_c = (y_end > 9'(PANEL_HEIGHT)) ? 9'(PANEL_HEIGHT) : y_end;
    assign x_last  = x_end_c - 9'd1;
    assign y_last  = y_end_c - 9'd1;
    assign y_page      = y_w >> 3;
    assign y_last_page = y_last >> 3;
    assign rect_ok = x_on && y_on && (x_end_c > x_w) && (y_end_c > y_w);

    assign b_col      = x_w + {2'b00, cmd.src_col};
    assign b_page     = y_page + {6'd0, cmd.src_row};
    assign b_page_inc = b_page + 9'd1;
    assign b_ok       = (b_col < 9'(PANEL_WIDTH)) && (b_page < 9'(PAGE_COUNT));
    assign b_two      = (cmd.y[2:0] != 3'd0) && (b_page_inc < 9'(PAGE_COUNT));
    assign b_shifted  = {8'd0, cmd.src_byte} << cmd.y[2:0];

    always_comb
    begin
        setup_walk       = 1'b0;
        setup_applied    = 1'b0;
        setup_page_start = y_page[PAGE_W-1:0];
        setup_page_end   = y_page[PAGE_W-1:0];
        setup_col_start  = x_w[COL_W-1:0];
        setup_col_end    = x_w[COL_W-1:0];
        setup_y_lo       = cmd.y[2:0];
        setup_y_hi       = cmd.y[2:0];
        setup_kind       = KIND_OR;
        setup_blit       = 1'b0;
        case (cmd.op)
            OP_CLEAR_ALL, OP_INVERT_ALL:
            begin
                setup_walk       = 1'b1;
                setup_applied    = 1'b1;
                setup_page_start = '0;
                setup_page_end   = PAGE_W'(PAGE_COUNT - 1);
                setup_col_start  = '0;
                setup_col_end    = COL_W'(PANEL_WIDTH - 1);
                setup_y_lo       = 3'd0;
                setup_y_hi       = 3'd7;
                setup_kind       = (cmd.op == OP_CLEAR_ALL) ? KIND_ANDN : KIND_XOR;
            end
            OP_SET_PIXEL, OP_READ:
            begin
                setup_walk    = x_on && y_on;
                setup_applied = x_on && y_on;
                setup_kind    = (cmd.op == OP_READ) ? KIND_READ : KIND_OR;
            end
            OP_CLEAR_RECT, OP_INVERT_RECT:
            begin
                setup_walk     = rect_ok;
                setup_applied  = rect_ok;
                setup_page_end = y_last_page[PAGE_W-1:0];
                setup_col_end  = x_last[COL_W-1:0];
                setup_y_hi     = y_last[2:0];
                setup_kind     = (cmd.op == OP_CLEAR_RECT) ? KIND_ANDN : KIND_XOR;
            end
            OP_BLIT_BYTE:
            begin
                setup_walk       = b_ok;
                setup_applied    = b_ok;
                setup_page_start = b_page[PAGE_W-1:0];
                setup_page_end   = b_two ? b_page_inc[PAGE_W-1:0] : b_page[PAGE_W-1:0];
                setup_col_start  = b_col[COL_W-1:0];
                setup_col_end    = b_col[COL_W-1:0];
                setup_kind       = KIND_OR;
                setup_blit       = 1'b1;
            end
            default:
            begin
                setup_walk    = 1'b0;
                setup_applied = 1'b0;
            end
        endcase
    end

    assign walk_addr  = row_base_reg + ADDR_W'(col_reg);
    assign mask_lo    = (page_reg == page_start_reg) ? y_lo_reg : 3'd0;
    assign mask_hi    = (page_reg == page_end_reg) ? y_hi_reg : 3'd7;
    assign range_mask = (8'hFF << mask_lo) & (8'hFF >> (3'd7 - mask_hi));
    assign walk_mask  = blit_reg ? ((page_reg == page_start_reg) ? blit_lo_reg : blit_hi_reg)
                                 : range_mask;

    always_comb
    begin
        case (p1_kind_reg)
            KIND_ANDN: mem_wdata = mem_rdata_reg & ~p1_mask_reg;
            KIND_XOR:  mem_wdata = mem_rdata_reg ^ p1_mask_reg;
            KIND_OR:   mem_wdata = mem_rdata_reg | p1_mask_reg;
            default:   mem_wdata = mem_rdata_reg;
        endcase
    end

    assign mem_we = p1_valid_reg && (p1_kind_reg != KIND_READ);

    always_comb
    begin
        state_next       = state_reg;
        report_next      = report_reg;
        page_next        = page_reg;
        page_start_next  = page_start_reg;
        page_end_next    = page_end_reg;
        col_next         = col_reg;
        col_start_next   = col_start_reg;
        col_end_next     = col_end_reg;
        row_base_next    = row_base_reg;
        y_lo_next        = y_lo_reg;
        y_hi_next        = y_hi_reg;
        kind_next        = kind_reg;
        blit_next        = blit_reg;
        blit_lo_next     = blit_lo_reg;
        blit_hi_next     = blit_hi_reg;
        res_applied_next = res_applied_reg;
        res_data_next    = res_data_reg;
        p1_valid_next    = 1'b0;
        p1_addr_next     = walk_addr;
        p1_mask_next     = walk_mask;
        p1_kind_next     = kind_reg;
        res_valid_next   = res_valid_reg && !res_ready;
        res_next         = res_reg;

        if (p1_valid_reg && (p1_kind_reg == KIND_READ))
        begin
            res_data_next = mem_rdata_reg;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    report_next      = 1'b1;
                    res_data_next    = 8'd0;
                    res_applied_next = setup_applied;
                    page_next        = setup_page_start;
                    page_start_next  = setup_page_start;
                    page_end_next    = setup_page_end;
                    col_next         = setup_col_start;
                    col_start_next   = setup_col_start;
                    col_end_next     = setup_col_end;
                    row_base_next    = ADDR_W'(int'(setup_page_start) * PANEL_WIDTH);
                    y_lo_next        = setup_y_lo;
                    y_hi_next        = setup_y_hi;
                    kind_next        = setup_kind;
                    blit_next        = setup_blit;
                    blit_lo_next     = b_shifted[7:0];
                    blit_hi_next     = b_shifted[15:8];
                    state_next       = setup_walk ? S_WALK : S_FINISH;
                end
            end
            S_WALK:
            begin
                p1_valid_next = 1'b1;
                if (col_reg == col_end_reg)
                begin
                    if (page_reg == page_end_reg)
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        page_next     = page_reg + PAGE_W'(1);
                        row_base_next = row_base_reg + ADDR_W'(PANEL_WIDTH);
                        col_next      = col_start_reg;
                    end
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
            end
            S_DRAIN:
            begin
                // The last byte is written back in this cycle.
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!report_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (!res_valid_reg || res_ready)
                begin
                    res_valid_next     = 1'b1;
                    res_next.read_data = res_data_reg;
                    res_next.applied   = res_applied_reg;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The walk registers come out of reset set up for a full-store clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_WALK;
            report_reg      <= 1'b0;
            page_reg        <= '0;
            page_start_reg  <= '0;
            page_end_reg    <= PAGE_W'(PAGE_COUNT - 1);
            col_reg         <= '0;
            col_start_reg   <= '0;
            col_end_reg     <= COL_W'(PANEL_WIDTH - 1);
            row_base_reg    <= '0;
            y_lo_reg        <= 3'd0;
            y_hi_reg        <= 3'd7;
            kind_reg        <= KIND_ANDN;
            blit_reg        <= 1'b0;
            blit_lo_reg     <= 8'd0;
            blit_hi_reg     <= 8'd0;
            p1_valid_reg    <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            report_reg      <= report_next;
            page_reg        <= page_next;
            page_start_reg  <= page_start_next;
            page_end_reg    <= page_end_next;
            col_reg         <= col_next;
            col_start_reg   <= col_start_next;
            col_end_reg     <= col_end_next;
            row_base_reg    <= row_base_next;
            y_lo_reg        <= y_lo_next;
            y_hi_reg        <= y_hi_next;
            kind_reg        <= kind_next;
            blit_reg        <= blit_next;
            blit_lo_reg     <= blit_lo_next;
            blit_hi_reg     <= blit_hi_next;
            p1_valid_reg    <= p1_valid_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_applied_reg <= res_applied_next;
        res_data_reg    <= res_data_next;
        p1_addr_reg     <= p1_addr_next;
        p1_mask_reg     <= p1_mask_next;
        p1_kind_reg     <= p1_kind_next;
        res_reg         <= res_next;
    end

    // Frame store: the write-back of one byte overlaps the read of the next.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[p1_addr_reg] <= mem_wdata;
        end
        mem_rdata_reg <= mem[walk_addr];
    end

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
